// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the frame decoder RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define HSFD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define HSFD_NEVER(label, clk, rst_n, expr, msg) \
	`HSFD_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

// ----- rtl/core/hsfd_pkg.sv -----
// Types, constants and the CRC-8 step for the measurement frame decoder.
// No dependencies; imported by the interface, tracker, scaler and top-level files.
package hsfd_pkg;

	localparam logic [7:0]  CRC_POLY      = 8'h31;
	localparam logic [7:0]  CRC_INIT      = 8'hFF;
	localparam logic [15:0] TEMP_SPAN     = 16'd17500;
	localparam logic [14:0] TEMP_OFFSET   = 15'd4500;
	localparam logic [15:0] HUM_SPAN      = 16'd10000;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_TEMP_CRC = 2'd1,
		STATUS_HUM_CRC  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		POS_T_MSB = 3'd0,
		POS_T_LSB = 3'd1,
		POS_T_CRC = 3'd2,
		POS_H_MSB = 3'd3,
		POS_H_LSB = 3'd4,
		POS_H_CRC = 3'd5
	} byte_pos_t;

	typedef struct packed {
		logic [15:0] temp_word;
		logic [15:0] hum_word;
		logic        temp_bad;
		logic        hum_bad;
	} frame_done_t;

	function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/hsfd_ifs.sv -----
// Valid/ready channel interfaces for received bytes and decoded results.
// Depends on hsfd_pkg for the status type.
interface hsfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, rx_byte, frame_start, input ready);
	modport sink (input valid, rx_byte, frame_start, output ready);
endinterface

interface hsfd_out_if import hsfd_pkg::*;;
	logic               valid;
	logic               ready;
	logic signed [14:0] temperature_centi;
	logic        [13:0] humidity_centi;
	status_t            status;

	modport source (output valid, temperature_centi, humidity_centi, status, input ready);
	modport sink (input valid, temperature_centi, humidity_centi, status, output ready);
endinterface

// ----- rtl/core/hsfd_frame_tracker.sv -----
// Byte position, running CRC and captured words of the frame in progress.
// Depends on hsfd_pkg for the CRC step, position codes and the frame struct.
module hsfd_frame_tracker import hsfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  byte_in,
	input  logic        start_in,
	output logic        last_byte,
	output frame_done_t done
);

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] temp_word_q;
	logic [15:0] hum_word_q;
	logic        temp_bad_q;
	logic [2:0]  pos_eff;

	// A start mark, or an unreachable position, restarts the frame.
	assign pos_eff   = (start_in || pos_q > POS_H_CRC) ? POS_T_MSB : pos_q;
	assign last_byte = (pos_eff == POS_H_CRC);

	assign done.temp_word = temp_word_q;
	assign done.hum_word  = hum_word_q;
	assign done.temp_bad  = temp_bad_q;
	assign done.hum_bad   = (crc_q != byte_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_T_MSB;
			crc_q       <= CRC_INIT;
			temp_word_q <= '0;
			hum_word_q  <= '0;
			temp_bad_q  <= 1'b0;
		end else if (step) begin
			pos_q <= (pos_eff >= POS_H_CRC) ? POS_T_MSB : pos_eff + 3'd1;
			case (pos_eff)
				POS_T_MSB: begin
					temp_word_q <= {byte_in, 8'h00};
					crc_q       <= crc8_feed(CRC_INIT, byte_in);
				end
				POS_T_LSB: begin
					temp_word_q <= {temp_word_q[15:8], byte_in};
					crc_q       <= crc8_feed(crc_q, byte_in);
				end
				POS_T_CRC: begin
					temp_bad_q <= (crc_q != byte_in);
					crc_q      <= CRC_INIT;
				end
				POS_H_MSB: begin
					hum_word_q <= {byte_in, 8'h00};
					crc_q      <= crc8_feed(CRC_INIT, byte_in);
				end
				POS_H_LSB: begin
					hum_word_q <= {hum_word_q[15:8], byte_in};
					crc_q      <= crc8_feed(crc_q, byte_in);
				end
				default: begin
					crc_q <= CRC_INIT;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/hsfd_scaler.sv -----
// Converts checked raw words into centi-degree and centi-percent values and a CRC status.
// Depends on hsfd_pkg for the scale constants, status codes and frame struct.
module hsfd_scaler import hsfd_pkg::*; (
	input  frame_done_t        done,
	output logic signed [14:0] temperature_centi,
	output logic        [13:0] humidity_centi,
	output status_t            status
);

	logic [31:0] temp_prod;
	logic [31:0] hum_prod;
	logic [14:0] temp_diff;

	assign temp_prod = 32'(done.temp_word) * 32'(TEMP_SPAN);
	assign hum_prod  = 32'(done.hum_word) * 32'(HUM_SPAN);
	// The floor quotient stays below 17500, so the wrapped difference is the
	// correct two's complement value.
	assign temp_diff = temp_prod[30:16] - TEMP_OFFSET;

	always_comb begin
		temperature_centi = '0;
		humidity_centi    = '0;
		if (done.temp_bad) begin
			status = STATUS_TEMP_CRC;
		end else begin
			temperature_centi = $signed(temp_diff);
			if (done.hum_bad) begin
				status = STATUS_HUM_CRC;
			end else begin
				status         = STATUS_OK;
				humidity_centi = hum_prod[29:16];
			end
		end
	end

endmodule

// ----- rtl/core/humidity_sensor_frame_decoder.sv -----
// Top level of the measurement frame decoder: input and result registers.
// Depends on hsfd_pkg, hsfd_ifs, hsfd_frame_tracker, hsfd_scaler, assert_macros.svh.
//
//   channel   direction   carries
//   rx        in          rx_byte, frame_start
//   result    out         temperature_centi, humidity_centi, status
//
// One byte is accepted per cycle unless a last byte waits on a stalled result; the sixth
// byte passes the input register, then the result register, before a result is offered.
// Reset clears the frame position, sets the running CRC to 0xFF, empties both stages.
// A stalled result holds; a byte that does not end a frame still drains past it.
`include "assert_macros.svh"

module humidity_sensor_frame_decoder import hsfd_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	hsfd_in_if.sink   rx,
	hsfd_out_if.source result
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               start_s1;
	logic               valid_s2;
	logic signed [14:0] temp_s2;
	logic        [13:0] hum_s2;
	status_t            status_s2;

	logic               last_byte;
	logic               s2_free;
	logic               advance_s1;
	frame_done_t        done;
	logic signed [14:0] temp_c;
	logic        [13:0] hum_c;
	status_t            status_c;

	assign s2_free    = !valid_s2 || result.ready;
	assign advance_s1 = valid_s1 && (!last_byte || s2_free);
	assign rx.ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1  <= rx.rx_byte;
			start_s1 <= rx.frame_start;
		end
	end

	hsfd_frame_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance_s1),
		.byte_in   (byte_s1),
		.start_in  (start_s1),
		.last_byte (last_byte),
		.done      (done)
	);

	hsfd_scaler u_scaler (
		.done              (done),
		.temperature_centi (temp_c),
		.humidity_centi    (hum_c),
		.status            (status_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= advance_s1 && last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && advance_s1 && last_byte) begin
			temp_s2   <= temp_c;
			hum_s2    <= hum_c;
			status_s2 <= status_c;
		end
	end

	assign result.valid             = valid_s2;
	assign result.temperature_centi = temp_s2;
	assign result.humidity_centi    = hum_s2;
	assign result.status            = status_s2;

	`HSFD_ASSERT(a_empty_s1_ready, clk, arst_n, !valid_s1 |-> rx.ready,
		"input stage empty but not ready")
	`HSFD_ASSERT(a_frame_end_result, clk, arst_n, (advance_s1 && last_byte) |=> valid_s2,
		"frame end did not load a result")
	`HSFD_NEVER(a_temp_err_zero, clk, arst_n,
		valid_s2 && status_s2 == STATUS_TEMP_CRC && (temp_s2 != '0 || hum_s2 != '0),
		"temperature CRC error with nonzero fields")

endmodule
